// ===== src/acrc_pkg.sv =====
package acrc_pkg;

  typedef enum logic [1:0] {
    ModeSlow  = 2'd0,
    ModeAvoid = 2'd1,
    ModeFast  = 2'd2
  } mode_t;

  // configuration register indexes
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 32;
  localparam logic [CfgIdxW-1:0] CfgChunkMin   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgChunkMax   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgRateMin    = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgRateMax    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgTimeoutMin = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgTimeoutMax = 3'd5;
  localparam logic [CfgIdxW-1:0] CfgWindowMin  = 3'd6;
  localparam logic [CfgIdxW-1:0] CfgWindowMax  = 3'd7;

  // Q2.16 scale factors, 18 bits so that a plain doubling fits
  localparam int FactorW = 18;
  localparam logic [FactorW-1:0] QUnit       = 18'd65536;
  localparam logic [FactorW-1:0] QDouble     = 18'd131072;
  localparam logic [FactorW-1:0] QTenthUp    = 18'd72089;
  localparam logic [FactorW-1:0] QTenthDown  = 18'd58982;
  localparam logic [FactorW-1:0] QHalf       = 18'd32768;
  localparam logic [FactorW-1:0] QOnePct     = 18'd66191;
  localparam logic [FactorW-1:0] QFivePct    = 18'd68812;
  localparam logic [FactorW-1:0] QMinus5Pct  = 18'd62259;
  localparam logic [12:0]        QOneTenth   = 13'd6553;

  // floor(x / 5) = (x * Div5Recip) >> Div5Shift, exact for x below 2**22
  localparam logic [19:0] Div5Recip = 20'd838861;
  localparam int          Div5Shift = 22;
  localparam logic [17:0] TimeoutBias = 18'd20;

  // reset values
  localparam logic [24:0] ChunkMinReset   = 25'd1024;
  localparam logic [24:0] ChunkMaxReset   = 25'd65536;
  localparam logic [31:0] RateMinReset    = 32'd65536;
  localparam logic [31:0] RateMaxReset    = 32'd104857600;
  localparam logic [15:0] TimeoutMinReset = 16'd50;
  localparam logic [15:0] TimeoutMaxReset = 16'd5000;
  localparam logic [23:0] WindowMinReset  = 24'd256;
  localparam logic [23:0] WindowMaxReset  = 24'd16384;
  localparam logic [24:0] ChunkReset      = 25'd8192;
  localparam logic [39:0] RateReset       = 40'd268435456;
  localparam logic [23:0] WindowReset     = 24'd256;
  localparam logic [24:0] WindowStep      = 25'd256;

endpackage

// ===== src/adaptive_congestion_rate_control.sv =====
// AIMD style congestion control. Each item on the input channel (in_valid /
// in_ready) is one metrics report: round_trip, loss_rate, link_bandwidth.
// Each report gives exactly one item on the output channel (out_valid /
// out_ready): chunk size, send rate, retry timeout, congestion window and
// mode. Limits are set through cfg_write / cfg_index / cfg_data, one
// register per cycle; the user must write them only while no report is in
// flight, and the block itself does not enforce this. One input register,
// then the full update (constant scaling, compares, clamps), combinational,
// into the state and result registers; out_valid rises once the result is
// loaded. Throughput is one report per cycle while the receiver takes
// results; the update of chunk, rate, window and mode state closes between
// the input register and the state registers, which sets the rate.
// When the receiver stalls, the result holds and the input register can
// still take one more report; in_ready drops only when both are full.
// Reset (rst, synchronous) empties both stages, loads the default limits and
// returns the controller to slow start with its initial chunk, rate and
// window.
module adaptive_congestion_rate_control (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [19:0] round_trip,
  input  logic [13:0] loss_rate,
  input  logic [31:0] link_bandwidth,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [24:0] chunk_size,
  output logic [31:0] send_rate,
  output logic [15:0] retry_timeout,
  output logic [23:0] cong_window,
  output logic [1:0]  cong_mode,
  input  logic        cfg_write,
  input  logic [acrc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [acrc_pkg::CfgDataW-1:0] cfg_data
);

  // limits
  logic [24:0] chunk_min, chunk_max;
  logic [31:0] rate_min, rate_max;
  logic [15:0] timeout_min, timeout_max;
  logic [23:0] window_min, window_max;

  // controller state
  logic [24:0]     chunk_reg, chunk_next;
  logic [39:0]     rate_reg, rate_next;
  logic [23:0]     window_reg, window_next;
  acrc_pkg::mode_t mode_reg, mode_next;

  // input stage
  logic        s1_valid;
  logic [19:0] s1_rtt;
  logic [13:0] s1_loss;
  logic [31:0] s1_bw;

  logic [15:0] timeout_next;
  logic        fire;

  assign fire     = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || fire;

  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_min   <= acrc_pkg::ChunkMinReset;
      chunk_max   <= acrc_pkg::ChunkMaxReset;
      rate_min    <= acrc_pkg::RateMinReset;
      rate_max    <= acrc_pkg::RateMaxReset;
      timeout_min <= acrc_pkg::TimeoutMinReset;
      timeout_max <= acrc_pkg::TimeoutMaxReset;
      window_min  <= acrc_pkg::WindowMinReset;
      window_max  <= acrc_pkg::WindowMaxReset;
    end else if (cfg_write) begin
      unique case (cfg_index)
        acrc_pkg::CfgChunkMin:   chunk_min   <= cfg_data[24:0];
        acrc_pkg::CfgChunkMax:   chunk_max   <= cfg_data[24:0];
        acrc_pkg::CfgRateMin:    rate_min    <= cfg_data;
        acrc_pkg::CfgRateMax:    rate_max    <= cfg_data;
        acrc_pkg::CfgTimeoutMin: timeout_min <= cfg_data[15:0];
        acrc_pkg::CfgTimeoutMax: timeout_max <= cfg_data[15:0];
        acrc_pkg::CfgWindowMin:  window_min  <= cfg_data[23:0];
        acrc_pkg::CfgWindowMax:  window_max  <= cfg_data[23:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_rtt  <= round_trip;
      s1_loss <= loss_rate;
      s1_bw   <= link_bandwidth;
    end
  end

  // ---------------- chunk size ----------------
  logic [17:0] chunk_factor;
  logic [41:0] chunk_prod;
  logic [28:0] chunk_scaled, chunk_cap, chunk_capped, chunk_lo, chunk_hi, chunk_t;
  logic [44:0] cap_prod;

  always_comb begin
    if (s1_loss < 14'd100 && s1_rtt < 20'd500) begin
      chunk_factor = acrc_pkg::QTenthUp;
    end else if (s1_loss > 14'd500 || s1_rtt > 20'd2000) begin
      chunk_factor = acrc_pkg::QTenthDown;
    end else begin
      chunk_factor = acrc_pkg::QUnit;
    end
    chunk_prod   = {17'd0, chunk_reg} * {24'd0, chunk_factor};
    chunk_scaled = {3'd0, chunk_prod[41:16]};
    cap_prod     = {13'd0, s1_bw} * {32'd0, acrc_pkg::QOneTenth};
    chunk_cap    = cap_prod[44:16];
    chunk_capped = (chunk_cap < chunk_scaled) ? chunk_cap : chunk_scaled;
    chunk_lo     = {4'd0, chunk_min};
    chunk_hi     = {4'd0, chunk_max};
    // raise to the minimum first, then the maximum wins
    chunk_t      = (chunk_capped < chunk_lo) ? chunk_lo : chunk_capped;
    chunk_t      = (chunk_t > chunk_hi) ? chunk_hi : chunk_t;
    chunk_next   = chunk_t[24:0];
  end

  // ---------------- rate and mode ----------------
  logic [17:0] rate_factor;
  logic [57:0] rate_prod;
  logic [41:0] rate_scaled, rate_lo, rate_hi, rate_t;

  always_comb begin
    mode_next = mode_reg;
    unique case (mode_reg)
      acrc_pkg::ModeSlow: begin
        if (s1_loss > 14'd100 || s1_rtt > 20'd2000) begin
          mode_next   = acrc_pkg::ModeAvoid;
          rate_factor = acrc_pkg::QHalf;
        end else begin
          rate_factor = acrc_pkg::QDouble;
        end
      end
      acrc_pkg::ModeAvoid: begin
        if (s1_loss < 14'd10 && s1_rtt < 20'd1000) begin
          rate_factor = acrc_pkg::QTenthUp;
        end else if (s1_loss > 14'd500 || s1_rtt > 20'd3000) begin
          mode_next   = acrc_pkg::ModeFast;
          rate_factor = acrc_pkg::QHalf;
        end else begin
          rate_factor = acrc_pkg::QOnePct;
        end
      end
      default: begin
        if (s1_loss < 14'd100 && s1_rtt < 20'd2000) begin
          mode_next   = acrc_pkg::ModeAvoid;
          rate_factor = acrc_pkg::QFivePct;
        end else begin
          rate_factor = acrc_pkg::QMinus5Pct;
        end
      end
    endcase
    rate_prod   = {18'd0, rate_reg} * {40'd0, rate_factor};
    rate_scaled = rate_prod[57:16];
    rate_lo     = {2'd0, rate_min, 8'd0};
    rate_hi     = {2'd0, rate_max, 8'd0};
    rate_t      = (rate_scaled < rate_lo) ? rate_lo : rate_scaled;
    rate_t      = (rate_t > rate_hi) ? rate_hi : rate_t;
    rate_next   = rate_t[39:0];
  end

  // ---------------- retry timeout ----------------
  logic [39:0] div5_prod;
  logic [17:0] tmo_raw, tmo_lo, tmo_hi, tmo_t;

  always_comb begin
    div5_prod    = {20'd0, s1_rtt} * {20'd0, acrc_pkg::Div5Recip};
    tmo_raw      = div5_prod[39:acrc_pkg::Div5Shift] + acrc_pkg::TimeoutBias;
    tmo_lo       = {2'd0, timeout_min};
    tmo_hi       = {2'd0, timeout_max};
    tmo_t        = (tmo_raw < tmo_lo) ? tmo_lo : tmo_raw;
    tmo_t        = (tmo_t > tmo_hi) ? tmo_hi : tmo_t;
    timeout_next = tmo_t[15:0];
  end

  // ---------------- congestion window ----------------
  logic [24:0] win_t, win_lo, win_hi;

  always_comb begin
    if (s1_loss < 14'd100) begin
      // uses the mode the rate step just decided
      if (mode_next == acrc_pkg::ModeSlow) begin
        win_t = {window_reg, 1'b0};
      end else begin
        win_t = {1'b0, window_reg} + acrc_pkg::WindowStep;
      end
    end else if (s1_loss > 14'd500) begin
      win_t = {2'd0, window_reg[23:1]};
    end else begin
      win_t = {1'b0, window_reg};
    end
    win_lo      = {1'b0, window_min};
    win_hi      = {1'b0, window_max};
    win_t       = (win_t < win_lo) ? win_lo : win_t;
    win_t       = (win_t > win_hi) ? win_hi : win_t;
    window_next = win_t[23:0];
  end

  // ---------------- state and result ----------------
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_reg  <= acrc_pkg::ChunkReset;
      rate_reg   <= acrc_pkg::RateReset;
      window_reg <= acrc_pkg::WindowReset;
      mode_reg   <= acrc_pkg::ModeSlow;
      out_valid  <= 1'b0;
    end else begin
      if (fire) begin
        chunk_reg  <= chunk_next;
        rate_reg   <= rate_next;
        window_reg <= window_next;
        mode_reg   <= mode_next;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      retry_timeout <= timeout_next;
    end
  end

  // state only moves when a result is loaded, so it doubles as the result
  assign chunk_size  = chunk_reg;
  assign send_rate   = rate_reg[39:8];
  assign cong_window = window_reg;
  assign cong_mode   = mode_reg;

endmodule
